// File: design/diode_ladder_lowpass_filter_top_macros.svh
// ----------------------------------------------------------------------------
// Diode ladder low-pass filter assertion macros
// Shared concurrent assertion forms, active in simulation and empty for
// synthesis.
// ----------------------------------------------------------------------------
`ifndef DIODE_LADDER_LOWPASS_FILTER_TOP_MACROS_SVH
`define DIODE_LADDER_LOWPASS_FILTER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define DLLP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define DLLP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DLLP_ASSERT_IMP(lbl, ante, cons, msg)
`define DLLP_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// File: design/dllp_pkg.sv
// ----------------------------------------------------------------------------
// Diode ladder low-pass filter package
// Number formats, tanh table generation, microcode program and shared types.
// ----------------------------------------------------------------------------
package dllp_pkg;

  localparam int SAMPLE_BITS        = 24;
  localparam int TANH_TABLE_ENTRIES = 1024;

  localparam int FRAC_BITS   = SAMPLE_BITS - 2;
  localparam int AW          = SAMPLE_BITS + 4;
  localparam int TAB_W       = FRAC_BITS + 1;
  localparam int TANH_POINTS = TANH_TABLE_ENTRIES + 1;
  localparam int ROM_AW      = $clog2(TANH_POINTS);
  localparam int MAW         = AW;
  localparam int MBW         = SAMPLE_BITS;
  localparam int PW          = MAW + MBW;
  localparam int COEF_W      = 16;
  localparam int RND_SH      = (FRAC_BITS < 30) ? (29 - FRAC_BITS) : 0;

  localparam logic [COEF_W-1:0] GAIN_MIN = 16'd7;
  localparam logic [COEF_W-1:0] GAIN_MAX = 16'd65529;
  localparam logic [COEF_W-1:0] CUTOFF_RESET    = 16'd6554;
  localparam logic [COEF_W-1:0] RESONANCE_RESET = 16'd0;
  localparam logic [COEF_W-1:0] HPGAIN_RESET    = 16'd852;

  localparam logic signed [AW-1:0] S_MAX =
    {{(AW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [AW-1:0] S_MIN =
    {{(AW-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

  localparam logic [63:0] Q28_ONE = 64'd1 << 28;

  localparam int UCODE_LEN = 31;
  localparam int STEP_W    = $clog2(UCODE_LEN);
  localparam logic [STEP_W-1:0] STEP_LOOP = STEP_W'(14);

  typedef enum logic [1:0] {
    CFG_CUTOFF    = 2'd0,
    CFG_RESONANCE = 2'd1,
    CFG_HPGAIN    = 2'd2,
    CFG_NONE      = 2'd3
  } cfg_idx_e;

  typedef enum logic [4:0] {
    OP_HPDIFF,
    OP_MUL_HPG,
    OP_MUL_RES,
    OP_MUL_G,
    OP_RND,
    OP_HPUPD,
    OP_HPO,
    OP_X6,
    OP_TH_MAG,
    OP_TH_RD0,
    OP_TH_RD1,
    OP_TH_MUL,
    OP_TH_FIN,
    OP_FBSUB,
    OP_LDP,
    OP_LDS,
    OP_DIFF,
    OP_STUPD,
    OP_DONE
  } op_e;

  typedef enum logic {
    JMP_NONE,
    JMP_STAGE
  } jmp_e;

  typedef struct packed {
    op_e               op;
    jmp_e              jmp;
    logic [STEP_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    op_e        op;
    logic [1:0] stage;
    logic       load;
  } ctrl_t;

  typedef struct packed {
    logic [COEF_W-1:0] gain;
    logic [COEF_W-1:0] res;
    logic [COEF_W-1:0] hpg;
  } coef_t;

  typedef logic [TAB_W-1:0] tanh_tab_t [TANH_POINTS];

  function automatic ucode_t uc(input op_e op);
    ucode_t w;
    w.op     = op;
    w.jmp    = JMP_NONE;
    w.target = '0;
    return w;
  endfunction

  function automatic ucode_t ucode_fetch(input logic [STEP_W-1:0] step);
    ucode_t w;
    unique case (step)
      5'd0:    w = uc(OP_HPDIFF);
      5'd1:    w = uc(OP_MUL_HPG);
      5'd2:    w = uc(OP_RND);
      5'd3:    w = uc(OP_HPUPD);
      5'd4:    w = uc(OP_HPO);
      5'd5:    w = uc(OP_MUL_RES);
      5'd6:    w = uc(OP_RND);
      5'd7:    w = uc(OP_X6);
      5'd8:    w = uc(OP_TH_MAG);
      5'd9:    w = uc(OP_TH_RD0);
      5'd10:   w = uc(OP_TH_RD1);
      5'd11:   w = uc(OP_TH_MUL);
      5'd12:   w = uc(OP_TH_FIN);
      5'd13:   w = uc(OP_FBSUB);
      5'd14:   w = uc(OP_LDP);
      5'd15:   w = uc(OP_TH_MAG);
      5'd16:   w = uc(OP_TH_RD0);
      5'd17:   w = uc(OP_TH_RD1);
      5'd18:   w = uc(OP_TH_MUL);
      5'd19:   w = uc(OP_TH_FIN);
      5'd20:   w = uc(OP_LDS);
      5'd21:   w = uc(OP_TH_MAG);
      5'd22:   w = uc(OP_TH_RD0);
      5'd23:   w = uc(OP_TH_RD1);
      5'd24:   w = uc(OP_TH_MUL);
      5'd25:   w = uc(OP_TH_FIN);
      5'd26:   w = uc(OP_DIFF);
      5'd27:   w = uc(OP_MUL_G);
      5'd28:   w = uc(OP_RND);
      5'd29: begin
        w        = uc(OP_STUPD);
        w.jmp    = JMP_STAGE;
        w.target = STEP_LOOP;
      end
      default: w = uc(OP_DONE);
    endcase
    return w;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] c;
    if (v > S_MAX) begin
      c = S_MAX;
    end else if (v < S_MIN) begin
      c = S_MIN;
    end else begin
      c = v;
    end
    return c[SAMPLE_BITS-1:0];
  endfunction

  // Shift and subtract quotient, used only while the tanh table is built.
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic tanh_tab_t tanh_build();
    tanh_tab_t   tab;
    logic [63:0] z;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] e;
    logic [63:0] p;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] t;
    for (int i = 0; i < TANH_POINTS; i++) begin
      z    = udiv64(64'(i) << 27, 64'(TANH_TABLE_ENTRIES));
      sum  = Q28_ONE;
      term = Q28_ONE;
      for (int k = 1; k <= 14; k++) begin
        term = udiv64((term * z) >> 28, 64'(k));
        sum  = sum + term;
      end
      e   = sum;
      e   = (e * e) >> 28;
      e   = (e * e) >> 28;
      e   = (e * e) >> 28;
      p   = ((e >> 4) * (e >> 4)) >> 20;
      num = (p - Q28_ONE) >> 10;
      den = (p + Q28_ONE) >> 10;
      t   = udiv64(num << 30, den);
      if (FRAC_BITS < 30) begin
        t = (t + (64'd1 << RND_SH)) >> (30 - FRAC_BITS);
      end
      tab[i] = TAB_W'(t);
    end
    return tab;
  endfunction

endpackage

// File: design/dllp_datapath.sv
// ----------------------------------------------------------------------------
// Diode ladder low-pass filter datapath
// Stage and high-pass state, work registers, one shared multiplier and the
// interpolated tanh ROM, driven one control word per cycle.
// ----------------------------------------------------------------------------
module dllp_datapath (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  dllp_pkg::ctrl_t                         ctrl_i,
  input  dllp_pkg::coef_t                         coef_i,
  input  logic signed [dllp_pkg::SAMPLE_BITS-1:0] sample_i,
  output logic signed [dllp_pkg::SAMPLE_BITS-1:0] stage3_o
);

  localparam int SB = dllp_pkg::SAMPLE_BITS;
  localparam int AW = dllp_pkg::AW;
  localparam int PW = dllp_pkg::PW;
  localparam int RW = dllp_pkg::ROM_AW;
  localparam int TW = dllp_pkg::TAB_W;
  localparam dllp_pkg::tanh_tab_t TANH_ROM = dllp_pkg::tanh_build();

  logic signed [SB-1:0]   st_q [4];
  logic signed [SB-1:0]   hp_q;
  logic signed [SB-1:0]   x_q;
  logic signed [AW-1:0]   a_q, a_d;
  logic signed [AW-1:0]   p_q, p_d;
  logic signed [SB-1:0]   b_q;
  logic signed [SB-1:0]   th_q, th_d;
  logic [PW-1:0]          prod_q;
  logic                   mneg_q;
  logic                   big_q;
  logic [RW-1:0]          idx_q;
  logic [SB-1:0]          fr_q;
  logic [TW-1:0]          t0_q;
  logic [TW-1:0]          rom_q;
  logic [RW-1:0]          rom_addr;
  logic [dllp_pkg::MAW-1:0] a_abs;
  logic [dllp_pkg::MAW-1:0] mul_a;
  logic [dllp_pkg::MBW-1:0] mul_b;
  logic [PW-1:0]          prod_d;
  logic [PW-1:0]          rnd_sum;
  logic signed [AW-1:0]   rnd_val;
  logic [TW:0]            interp;
  logic signed [SB-1:0]   st_sel;
  logic signed [SB-1:0]   st_new;

  assign stage3_o = st_q[3];
  assign st_sel   = st_q[ctrl_i.stage];
  assign a_abs    = a_q[AW-1] ? dllp_pkg::MAW'(-a_q) : dllp_pkg::MAW'(a_q);
  assign rnd_sum  = prod_q + PW'(32768);
  assign rnd_val  = AW'(rnd_sum >> 16);
  assign interp   = (TW+1)'(t0_q) + (TW+1)'(prod_q[SB +: TW]);
  assign st_new   = dllp_pkg::sat(AW'(st_sel) + a_q);

  always_comb begin
    unique case (ctrl_i.op)
      dllp_pkg::OP_MUL_HPG: begin
        mul_a = a_abs;
        mul_b = dllp_pkg::MBW'(coef_i.hpg);
      end
      dllp_pkg::OP_MUL_RES: begin
        mul_a = a_abs;
        mul_b = dllp_pkg::MBW'(coef_i.res);
      end
      dllp_pkg::OP_MUL_G: begin
        mul_a = a_abs;
        mul_b = dllp_pkg::MBW'(coef_i.gain);
      end
      dllp_pkg::OP_TH_MUL: begin
        mul_a = dllp_pkg::MAW'(rom_q - t0_q);
        mul_b = fr_q;
      end
      default: begin
        mul_a = a_abs;
        mul_b = dllp_pkg::MBW'(dllp_pkg::TANH_TABLE_ENTRIES);
      end
    endcase
  end

  assign prod_d = PW'(mul_a) * PW'(mul_b);

  always_comb begin
    unique case (ctrl_i.op)
      dllp_pkg::OP_TH_RD0: rom_addr = big_q ? RW'(dllp_pkg::TANH_TABLE_ENTRIES)
                                            : prod_q[SB +: RW];
      dllp_pkg::OP_TH_RD1: rom_addr = big_q ? RW'(dllp_pkg::TANH_TABLE_ENTRIES)
                                            : idx_q + RW'(1);
      default:             rom_addr = idx_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rom_q <= TANH_ROM[rom_addr];
  end

  always_comb begin
    a_d  = a_q;
    p_d  = p_q;
    th_d = th_q;
    unique case (ctrl_i.op)
      dllp_pkg::OP_HPDIFF: a_d = AW'(st_q[3]) - AW'(hp_q);
      dllp_pkg::OP_RND:    a_d = mneg_q ? -rnd_val : rnd_val;
      dllp_pkg::OP_HPO:    a_d = AW'(dllp_pkg::sat(AW'(st_q[3]) - AW'(hp_q)));
      dllp_pkg::OP_X6:     a_d = (a_q <<< 2) + (a_q <<< 1);
      dllp_pkg::OP_TH_FIN: th_d = mneg_q ? -SB'(interp) : SB'(interp);
      dllp_pkg::OP_FBSUB:  p_d = AW'(x_q) - AW'(th_q);
      dllp_pkg::OP_LDP:    a_d = p_q;
      dllp_pkg::OP_LDS:    a_d = AW'(st_sel);
      dllp_pkg::OP_DIFF:   a_d = AW'(b_q) - AW'(th_q);
      dllp_pkg::OP_STUPD:  p_d = AW'(st_new);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    a_q  <= a_d;
    p_q  <= p_d;
    th_q <= th_d;
    if (ctrl_i.load) begin
      x_q <= sample_i;
    end
    if (ctrl_i.op == dllp_pkg::OP_LDS) begin
      b_q <= th_q;
    end
    if (ctrl_i.op == dllp_pkg::OP_MUL_HPG || ctrl_i.op == dllp_pkg::OP_MUL_RES ||
        ctrl_i.op == dllp_pkg::OP_MUL_G || ctrl_i.op == dllp_pkg::OP_TH_MAG) begin
      mneg_q <= a_q[AW-1];
    end
    if (ctrl_i.op == dllp_pkg::OP_TH_MAG) begin
      big_q <= a_abs >= dllp_pkg::MAW'(64'd1 << SB);
    end
    if (ctrl_i.op == dllp_pkg::OP_MUL_HPG || ctrl_i.op == dllp_pkg::OP_MUL_RES ||
        ctrl_i.op == dllp_pkg::OP_MUL_G || ctrl_i.op == dllp_pkg::OP_TH_MAG ||
        ctrl_i.op == dllp_pkg::OP_TH_MUL) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.op == dllp_pkg::OP_TH_RD0) begin
      idx_q <= prod_q[SB +: RW];
      fr_q  <= big_q ? '0 : prod_q[SB-1:0];
    end
    if (ctrl_i.op == dllp_pkg::OP_TH_RD1) begin
      t0_q <= rom_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_q <= '0;
      for (int i = 0; i < 4; i++) begin
        st_q[i] <= '0;
      end
    end else begin
      if (ctrl_i.op == dllp_pkg::OP_HPUPD) begin
        hp_q <= dllp_pkg::sat(AW'(hp_q) + a_q);
      end
      if (ctrl_i.op == dllp_pkg::OP_STUPD) begin
        st_q[ctrl_i.stage] <= st_new;
      end
    end
  end

endmodule

// File: design/diode_ladder_lowpass_filter_top.sv
// ----------------------------------------------------------------------------
// Diode ladder low-pass filter, top level
// Four-pole tanh-saturated ladder with high-pass resonance feedback, run by a
// microcoded sequencer over a shared datapath.
// ----------------------------------------------------------------------------
// Each input beat runs the whole microcode program before the next beat can
// be accepted. The run length is set by the single shared multiplier and the
// single-port tanh ROM, which together give five steps to each of the nine
// tanh lookups per sample, with the four ladder stages run as one loop of
// sixteen steps. The block holds off new input while a sample is in work,
// and the result waits in an output register so the next input beat can be
// taken before the result beat is taken.
// ----------------------------------------------------------------------------
`include "diode_ladder_lowpass_filter_top_macros.svh"

module diode_ladder_lowpass_filter_top (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [1:0]                              cfg_idx_i,
  input  logic [15:0]                             cfg_data_i,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic signed [dllp_pkg::SAMPLE_BITS-1:0] sample_in_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [dllp_pkg::SAMPLE_BITS-1:0] sample_out_o
);

  localparam int SW = dllp_pkg::STEP_W;

  logic [15:0]              cutoff_q, res_q, hpg_q;
  logic                     run_q, run_d;
  logic [SW-1:0]            step_q, step_d;
  logic [1:0]               stage_q, stage_d;
  logic                     out_valid_q, out_valid_d;
  logic signed [dllp_pkg::SAMPLE_BITS-1:0] out_q;
  logic signed [dllp_pkg::SAMPLE_BITS-1:0] stage3;
  logic                     in_acc;
  logic                     out_free;
  logic                     done_fire;
  dllp_pkg::ucode_t         ucode;
  dllp_pkg::ctrl_t          ctrl;
  dllp_pkg::coef_t          coef;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= dllp_pkg::CUTOFF_RESET;
      res_q    <= dllp_pkg::RESONANCE_RESET;
      hpg_q    <= dllp_pkg::HPGAIN_RESET;
    end else if (cfg_we_i) begin
      unique case (dllp_pkg::cfg_idx_e'(cfg_idx_i))
        dllp_pkg::CFG_CUTOFF:    cutoff_q <= cfg_data_i;
        dllp_pkg::CFG_RESONANCE: res_q    <= cfg_data_i;
        dllp_pkg::CFG_HPGAIN:    hpg_q    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    priority if (cutoff_q < dllp_pkg::GAIN_MIN) begin
      coef.gain = dllp_pkg::GAIN_MIN;
    end else if (cutoff_q > dllp_pkg::GAIN_MAX) begin
      coef.gain = dllp_pkg::GAIN_MAX;
    end else begin
      coef.gain = cutoff_q;
    end
    coef.res = res_q;
    coef.hpg = hpg_q;
  end

  assign ucode     = dllp_pkg::ucode_fetch(step_q);
  assign in_stall_o = run_q;
  assign in_acc    = in_valid_i && !run_q;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign done_fire = run_q && ucode.op == dllp_pkg::OP_DONE && out_free;

  always_comb begin
    ctrl.op    = run_q ? ucode.op : dllp_pkg::OP_DONE;
    ctrl.stage = stage_q;
    ctrl.load  = in_acc;
  end

  always_comb begin
    run_d   = run_q;
    step_d  = step_q;
    stage_d = stage_q;
    if (!run_q) begin
      if (in_acc) begin
        run_d  = 1'b1;
        step_d = '0;
      end
    end else begin
      unique case (ucode.op)
        dllp_pkg::OP_DONE: begin
          if (out_free) begin
            run_d = 1'b0;
          end
        end
        dllp_pkg::OP_FBSUB: begin
          stage_d = '0;
          step_d  = step_q + SW'(1);
        end
        dllp_pkg::OP_STUPD: begin
          stage_d = stage_q + 2'd1;
          if (ucode.jmp == dllp_pkg::JMP_STAGE && stage_q != 2'd3) begin
            step_d = ucode.target;
          end else begin
            step_d = step_q + SW'(1);
          end
        end
        default: step_d = step_q + SW'(1);
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (done_fire) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= 1'b0;
      step_q      <= '0;
      stage_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      run_q       <= run_d;
      step_q      <= step_d;
      stage_q     <= stage_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_fire) begin
      out_q <= stage3;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

  dllp_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .coef_i   (coef),
    .sample_i (sample_in_i),
    .stage3_o (stage3)
  );

  `DLLP_ASSERT_NXT(a_accept_starts, in_valid_i && !in_stall_o, run_q && step_q == '0, "accepted beat did not start the program")
  `DLLP_ASSERT_IMP(a_stage_idle, !run_q, stage_q == 2'd0, "stage counter not at zero while idle")
  `DLLP_ASSERT_NXT(a_done_delivers, done_fire, !run_q && out_valid_o, "finished sample not presented")

endmodule

// File: tb/diode_ladder_lowpass_filter_checker.sv
// ----------------------------------------------------------------------------
// Diode ladder low-pass filter checker
// Watches the register port and both sample channels. It keeps its own copy
// of the filter state and coefficients, predicts each output beat, and
// compares every output beat with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module diode_ladder_lowpass_filter_checker (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [1:0]                              cfg_idx_i,
  input  logic [15:0]                             cfg_data_i,
  input  logic                                    in_valid_i,
  input  logic                                    in_stall_i,
  input  logic signed [dllp_pkg::SAMPLE_BITS-1:0] sample_in_i,
  input  logic                                    out_valid_i,
  input  logic                                    out_stall_i,
  input  logic signed [dllp_pkg::SAMPLE_BITS-1:0] sample_out_i,
  output int                                      fail_count_o,
  output int                                      pending_o
);

  localparam int SB = dllp_pkg::SAMPLE_BITS;
  localparam int NT = dllp_pkg::TANH_TABLE_ENTRIES;
  localparam int FB = dllp_pkg::FRAC_BITS;
  localparam longint STATE_HI = (longint'(1) <<< (SB - 1)) - 1;
  localparam longint STATE_LO = -(longint'(1) <<< (SB - 1));
  localparam logic [63:0] ARG_SPAN = 64'd1 << SB;
  localparam logic [63:0] Q28_UNIT = 64'd1 << 28;

  logic [63:0] tanh_points [0:NT];

  logic [15:0] cutoff_q;
  logic [15:0] res_q;
  logic [15:0] hpg_q;
  longint      stage_q [4];
  longint      hp_q;

  logic signed [SB-1:0] expected_samples [$];
  logic signed [SB-1:0] want;
  int fails     = 0;
  int pending_q = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending_q;

  function automatic logic [63:0] tanh_point(input int i);
    logic [63:0] z;
    logic [63:0] acc;
    logic [63:0] term;
    logic [63:0] e;
    logic [63:0] p;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] t;
    z    = (64'(i) << 27) / 64'(NT);
    acc  = Q28_UNIT;
    term = Q28_UNIT;
    for (int k = 1; k <= 14; k++) begin
      term = ((term * z) >> 28) / 64'(k);
      acc  = acc + term;
    end
    e = acc;
    repeat (3) e = (e * e) >> 28;
    p   = ((e >> 4) * (e >> 4)) >> 20;
    num = (p - Q28_UNIT) >> 10;
    den = (p + Q28_UNIT) >> 10;
    t   = (num << 30) / den;
    if (FB < 30) begin
      t = (t + (64'd1 << (29 - FB))) >> (30 - FB);
    end
    return t;
  endfunction

  initial begin
    for (int i = 0; i <= NT; i++) begin
      tanh_points[i] = tanh_point(i);
    end
  end

  function automatic longint clip(input longint v);
    if (v > STATE_HI) begin
      return STATE_HI;
    end else if (v < STATE_LO) begin
      return STATE_LO;
    end
    return v;
  endfunction

  // Coefficient multiply, rounded half away from zero.
  function automatic longint scale_q16(input longint a, input logic [15:0] c);
    logic [63:0] mag;
    logic [63:0] r;
    mag = (a < 0) ? 64'(-a) : 64'(a);
    r   = (mag * 64'(c) + 64'd32768) >> 16;
    return (a < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint soft_clip(input longint a);
    logic [63:0] mag;
    logic [63:0] pos;
    logic [63:0] idx;
    logic [63:0] fr;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] r;
    mag = (a < 0) ? 64'(-a) : 64'(a);
    if (mag >= ARG_SPAN) begin
      r = tanh_points[NT];
    end else begin
      pos = mag * 64'(NT);
      idx = pos >> SB;
      fr  = pos & (ARG_SPAN - 64'd1);
      if (idx >= 64'(NT)) begin
        idx = 64'(NT - 1);
      end
      lo = tanh_points[idx];
      hi = tanh_points[idx + 1];
      r  = lo + (((hi - lo) * fr) >> SB);
    end
    return (a < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic logic signed [SB-1:0] filter_next(
    input logic signed [SB-1:0] x
  );
    logic [15:0] g;
    longint      hpo;
    longint      fb;
    longint      drive;
    g = cutoff_q;
    if (g < dllp_pkg::GAIN_MIN) begin
      g = dllp_pkg::GAIN_MIN;
    end else if (g > dllp_pkg::GAIN_MAX) begin
      g = dllp_pkg::GAIN_MAX;
    end
    hp_q  = clip(hp_q + scale_q16(stage_q[3] - hp_q, hpg_q));
    hpo   = clip(stage_q[3] - hp_q);
    fb    = soft_clip(6 * scale_q16(hpo, res_q));
    drive = longint'(x) - fb;
    for (int k = 0; k < 4; k++) begin
      stage_q[k] = clip(stage_q[k] + scale_q16(soft_clip(drive) - soft_clip(stage_q[k]), g));
      drive      = stage_q[k];
    end
    return SB'(stage_q[3]);
  endfunction

  task automatic report(input string what);
    $display("%0t: %s", $time, what);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q = dllp_pkg::CUTOFF_RESET;
      res_q    = dllp_pkg::RESONANCE_RESET;
      hpg_q    = dllp_pkg::HPGAIN_RESET;
      for (int k = 0; k < 4; k++) begin
        stage_q[k] = 0;
      end
      hp_q = 0;
      expected_samples.delete();
      pending_q <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          dllp_pkg::CFG_CUTOFF: begin
            cutoff_q = cfg_data_i;
          end
          dllp_pkg::CFG_RESONANCE: begin
            res_q = cfg_data_i;
          end
          dllp_pkg::CFG_HPGAIN: begin
            hpg_q = cfg_data_i;
          end
          default: begin
          end
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_samples.size() == 0) begin
          report($sformatf("output beat %0d with no input pending", sample_out_i));
        end else begin
          want = expected_samples.pop_front();
          if (sample_out_i !== want) begin
            report($sformatf("sample_out mismatch: got %0d, want %0d", sample_out_i, want));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_samples.push_back(filter_next(sample_in_i));
      end
      pending_q <= expected_samples.size();
    end
  end

endmodule

// File: tb/tb_diode_ladder_lowpass_filter_top.sv
// ----------------------------------------------------------------------------
// Diode ladder low-pass filter testbench
// Drives directed and random sample streams through the filter under several
// coefficient settings, with random gaps on the input and random stalls on
// the output. The checker beside the block predicts and compares each beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_diode_ladder_lowpass_filter_top;

  localparam int SB          = dllp_pkg::SAMPLE_BITS;
  localparam int NUM_PHASES  = 7;
  localparam int PHASE_BEATS = 118;
  localparam logic signed [SB-1:0] SAMPLE_TOP =
    {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SAMPLE_BOTTOM =
    {1'b1, {(SB-1){1'b0}}};

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [1:0]           cfg_idx_i   = dllp_pkg::CFG_NONE;
  logic [15:0]          cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic signed [SB-1:0] sample_in_i = '0;
  logic                 out_stall_i = 1'b0;
  logic                 in_stall_o;
  logic                 out_valid_o;
  logic signed [SB-1:0] sample_out_o;

  int fail_count;
  int pending_count;
  bit in_gaps    = 1'b0;
  bit out_stalls = 1'b0;

  logic [15:0] corner_coefs [9] = '{16'd0, 16'd1, 16'd6, 16'd7, 16'd8,
                                    16'd65528, 16'd65529, 16'd65530, 16'd65535};

  diode_ladder_lowpass_filter_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o)
  );

  diode_ladder_lowpass_filter_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .sample_in_i  (sample_in_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_i (sample_out_o),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (out_stalls && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    #20_000_000;
    $display("diode_ladder_lowpass_filter_top test failed");
    $finish;
  end

  task automatic drive_sample(input logic signed [SB-1:0] v);
    if (in_gaps && $urandom_range(0, 2) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_in_i <= v;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
  endtask

  task automatic write_reg(input dllp_pkg::cfg_idx_e idx, input logic [15:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  // The write to the unused index must leave the coefficients untouched.
  task automatic load_coefs(input logic [15:0] cut, input logic [15:0] res,
                            input logic [15:0] hpg);
    write_reg(dllp_pkg::CFG_CUTOFF, cut);
    write_reg(dllp_pkg::CFG_RESONANCE, res);
    write_reg(dllp_pkg::CFG_HPGAIN, hpg);
    write_reg(dllp_pkg::CFG_NONE, 16'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [15:0] pick_coef();
    if ($urandom_range(0, 2) == 0) begin
      return corner_coefs[$urandom_range(0, 8)];
    end
    return 16'($urandom_range(0, 65535));
  endfunction

  initial begin
    int sent;
    int style;
    int run_len;
    int half;
    logic signed [SB-1:0] amp;
    logic signed [SB-1:0] v;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    in_gaps    = 1'b1;
    out_stalls = 1'b1;
    drive_sample('0);
    drive_sample(SAMPLE_TOP);
    drive_sample(SAMPLE_BOTTOM);
    drive_sample(SB'(1));
    drive_sample(-SB'(1));
    drive_sample(SAMPLE_TOP);
    drive_sample(SAMPLE_TOP);
    drive_sample(SAMPLE_BOTTOM);
    drive_sample(SAMPLE_BOTTOM);
    drive_sample('0);
    settle();

    // Cutoff above its range and full resonance: the feedback drives tanh
    // past the end of its table.
    load_coefs(16'd65535, 16'd65535, 16'd65535);
    for (int n = 0; n < 8; n++) begin
      drive_sample((n % 4 < 2) ? SAMPLE_TOP : SAMPLE_BOTTOM);
    end
    settle();

    // Cutoff below its range, frozen high-pass memory.
    load_coefs(16'd0, 16'd40000, 16'd0);
    drive_sample(SAMPLE_TOP);
    drive_sample(SAMPLE_BOTTOM);
    drive_sample(SAMPLE_TOP);
    drive_sample(SAMPLE_BOTTOM);
    settle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 0) begin
        load_coefs(16'd65529, 16'd65535, 16'd852);
      end else begin
        load_coefs(pick_coef(), pick_coef(), pick_coef());
      end
      in_gaps    = (p < NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      out_stalls = (p < NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      sent = 0;
      while (sent < PHASE_BEATS) begin
        style   = $urandom_range(0, 19);
        run_len = $urandom_range(8, 32);
        half    = $urandom_range(1, 12);
        amp     = SB'($urandom_range(0, SAMPLE_TOP));
        for (int n = 0; n < run_len && sent < PHASE_BEATS; n++) begin
          if (style < 4) begin
            v = SB'($urandom);
          end else if (style < 14) begin
            v = ((n / half) % 2 == 0) ? amp : -amp;
          end else if (style < 17) begin
            v = SB'($urandom_range(0, 2047)) - SB'(1024);
          end else begin
            v = $urandom_range(0, 1) ? SAMPLE_TOP : SAMPLE_BOTTOM;
          end
          drive_sample(v);
          sent++;
        end
      end
      settle();
    end

    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("diode_ladder_lowpass_filter_top test passed");
    end else begin
      $display("diode_ladder_lowpass_filter_top test failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/dllp_pkg.sv
design/dllp_datapath.sv
design/diode_ladder_lowpass_filter_top.sv
tb/diode_ladder_lowpass_filter_checker.sv
tb/tb_diode_ladder_lowpass_filter_top.sv
